// ===== hdl/dpfh_pkg.sv =====
// ----------------------------------------------------------------------------
// dpfh_pkg
// Shared types, codes and widths of the demand paging fault handler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpfh_pkg;

  localparam int DEF_MAX_PAGES  = 256;
  localparam int DEF_MAX_FRAMES = 64;

  localparam int PAGE_W     = 8;
  localparam int ACT_W      = 3;
  localparam int FIDX_W     = 6;
  localparam int PROT_W     = 2;
  localparam int PC_W       = 9;
  localparam int FC_W       = 7;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

  localparam logic [PC_W-1:0] PAGE_COUNT_RST  = 9'd256;
  localparam logic [FC_W-1:0] FRAME_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_UNALLOC = 2'd0,
    ST_RAM     = 2'd1,
    ST_SWAP    = 2'd2
  } pg_state_e;

  typedef enum logic [PROT_W-1:0] {
    PROT_NO = 2'd0,
    PROT_RD = 2'd1,
    PROT_WR = 2'd2
  } prot_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_ERROR     = 3'd0,
    ACT_UPGRADE   = 3'd1,
    ACT_REPROTECT = 3'd2,
    ACT_ZERO_FILL = 3'd3,
    ACT_SWAP_IN   = 3'd4,
    ACT_EVICT     = 3'd5
  } act_e;

  typedef struct packed {
    pg_state_e state;
    logic      fresh;
    logic      dirty;
    prot_e     prot;
  } pg_entry_t;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic accept;
    logic eval;
    logic eval_v;
    logic out_load;
  } dpfh_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_victim;
    logic out_free;
  } dpfh_status_t;

endpackage

// ===== hdl/dpfh_datapath.sv =====
// ----------------------------------------------------------------------------
// dpfh_datapath
// Page table memory, configuration, frame fill count, result and output regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpfh_datapath import dpfh_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dpfh_cmd_t             cmd_i,
  output dpfh_status_t          status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PAGE_W-1:0]     fault_page_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ACT_W-1:0]      action_o,
  output logic [FIDX_W-1:0]     frame_index_o,
  output logic [PROT_W-1:0]     new_protection_o,
  output logic                  victim_valid_o,
  output logic [PAGE_W-1:0]     victim_page_o,
  output logic                  victim_writeback_o
);

  localparam int PW    = $clog2(MAX_PAGES);
  localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NFW   = $clog2(MAX_FRAMES + 1);
  localparam int CW_A  = ($clog2(MAX_PAGES + 1) > PC_W) ? $clog2(MAX_PAGES + 1) : PC_W;
  localparam int CNT_W = ($clog2(MAX_FRAMES + 1) > CW_A) ? $clog2(MAX_FRAMES + 1) : CW_A;

  typedef struct packed {
    logic [FW-1:0] frame;
    pg_entry_t     info;
  } pt_word_t;

  pt_word_t mem [MAX_PAGES];

  logic [PC_W-1:0]   page_count_q;
  logic [FC_W-1:0]   frame_count_q;
  logic [NFW-1:0]    k_q, k_d;
  logic [PW-1:0]     clr_q;
  logic [PAGE_W-1:0] page_q;
  logic [PAGE_W-1:0] f0_q, f0_d;
  pt_word_t          rdata_q;
  logic [PW-1:0]     rd_addr;

  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  pt_word_t          wr_data;
  pt_word_t          rst_word;

  logic [CNT_W-1:0]  ep, fc;
  logic [NFW-1:0]    nf;
  logic              in_range, free_ok;

  act_e              res_act_q, res_act_d;
  logic [FIDX_W-1:0] res_fidx_q, res_fidx_d;
  prot_e             res_prot_q, res_prot_d;
  logic              res_vv_q, res_vv_d;
  logic [PAGE_W-1:0] res_vp_q, res_vp_d;
  logic              res_vwb_q, res_vwb_d;

  logic              out_valid_q;
  act_e              out_act_q;
  logic [FIDX_W-1:0] out_fidx_q;
  prot_e             out_prot_q;
  logic              out_vv_q;
  logic [PAGE_W-1:0] out_vp_q;
  logic              out_vwb_q;

  // effective page and frame counts
  always_comb begin
    ep = (CNT_W'(page_count_q) > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                      : CNT_W'(page_count_q);
    fc = (frame_count_q == '0) ? CNT_W'(1) : CNT_W'(frame_count_q);
    if (fc > CNT_W'(MAX_FRAMES)) begin
      fc = CNT_W'(MAX_FRAMES);
    end
    if (fc > ep && ep != '0) begin
      fc = ep;
    end
    nf = NFW'(fc);
  end

  assign in_range = (CNT_W'(page_q) < CNT_W'(page_count_q)) &&
                    (CNT_W'(page_q) < CNT_W'(MAX_PAGES));
  assign free_ok  = (rdata_q.info.state != ST_SWAP) && (k_q < nf);

  assign rst_word = '{frame: '0, info: '{state: ST_UNALLOC, fresh: 1'b1,
                                          dirty: 1'b0, prot: PROT_NO}};

  assign rd_addr = cmd_i.eval ? PW'(f0_q) : PW'(fault_page_i);

  assign status_o.clr_last    = (clr_q == PW'(MAX_PAGES - 1));
  assign status_o.need_victim = in_range && (rdata_q.info.state != ST_RAM) &&
                                !free_ok && (k_q != '0);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = clr_q;
    wr_data    = rst_word;
    k_d        = k_q;
    f0_d       = f0_q;
    res_act_d  = res_act_q;
    res_fidx_d = res_fidx_q;
    res_prot_d = res_prot_q;
    res_vv_d   = res_vv_q;
    res_vp_d   = res_vp_q;
    res_vwb_d  = res_vwb_q;
    if (cmd_i.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd_i.eval) begin
      res_act_d  = ACT_ERROR;
      res_fidx_d = '0;
      res_prot_d = PROT_NO;
      res_vv_d   = 1'b0;
      res_vp_d   = '0;
      res_vwb_d  = 1'b0;
      wr_addr    = PW'(page_q);
      wr_data    = rdata_q;
      if (in_range) begin
        wr_en = 1'b1;
        if (rdata_q.info.state == ST_RAM) begin
          if (rdata_q.info.prot == PROT_RD) begin
            wr_data.info.prot  = PROT_WR;
            wr_data.info.dirty = 1'b1;
            res_act_d          = ACT_UPGRADE;
          end else begin
            res_act_d = ACT_REPROTECT;
          end
          res_prot_d = wr_data.info.prot;
          res_fidx_d = FIDX_W'(rdata_q.frame);
        end else if (free_ok) begin
          wr_data = '{frame: FW'(k_q), info: '{state: ST_RAM, fresh: 1'b1,
                                               dirty: 1'b0, prot: PROT_RD}};
          res_act_d  = ACT_ZERO_FILL;
          res_fidx_d = FIDX_W'(k_q);
          res_prot_d = PROT_RD;
          k_d        = NFW'(k_q + 1'b1);
          if (k_q == '0) begin
            f0_d = page_q;
          end
        end else begin
          res_act_d = (rdata_q.info.state == ST_SWAP) ? ACT_SWAP_IN : ACT_EVICT;
          wr_data.frame      = '0;
          wr_data.info.state = ST_RAM;
          wr_data.info.dirty = 1'b0;
          wr_data.info.prot  = PROT_RD;
          res_prot_d         = PROT_RD;
          if (k_q == '0) begin
            f0_d = page_q;
          end
        end
      end
    end else if (cmd_i.eval_v) begin
      wr_en              = 1'b1;
      wr_addr            = PW'(f0_q);
      wr_data            = rdata_q;
      wr_data.info.state = ST_SWAP;
      wr_data.info.fresh = 1'b0;
      res_vv_d           = 1'b1;
      res_vp_d           = f0_q;
      res_vwb_d          = rdata_q.info.dirty || rdata_q.info.fresh;
      f0_d               = page_q;
    end
    if (cfg_we_i) begin
      k_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q  <= PAGE_COUNT_RST;
      frame_count_q <= FRAME_COUNT_RST;
      k_q           <= '0;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_PAGE_COUNT:  page_count_q  <= cfg_data_i;
          CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[FC_W-1:0];
          default: ;
        endcase
      end
      k_q <= k_d;
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= PW'(clr_q + 1'b1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q <= fault_page_i;
    end
    f0_q       <= f0_d;
    res_act_q  <= res_act_d;
    res_fidx_q <= res_fidx_d;
    res_prot_q <= res_prot_d;
    res_vv_q   <= res_vv_d;
    res_vp_q   <= res_vp_d;
    res_vwb_q  <= res_vwb_d;
    if (cmd_i.out_load) begin
      out_act_q  <= res_act_q;
      out_fidx_q <= res_fidx_q;
      out_prot_q <= res_prot_q;
      out_vv_q   <= res_vv_q;
      out_vp_q   <= res_vp_q;
      out_vwb_q  <= res_vwb_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign action_o           = out_act_q;
  assign frame_index_o      = out_fidx_q;
  assign new_protection_o   = out_prot_q;
  assign victim_valid_o     = out_vv_q;
  assign victim_page_o      = out_vp_q;
  assign victim_writeback_o = out_vwb_q;

`ifndef SYNTHESIS
  a_victim_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval_v |-> rdata_q.info.state == ST_RAM)
    else $error("evicted page was not resident");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= nf)
    else $error("frame fill count beyond frame count");

  a_victim_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_vv_q) |-> (out_act_q == ACT_SWAP_IN || out_act_q == ACT_EVICT))
    else $error("victim reported without eviction");
`endif

endmodule

// ===== hdl/dpfh_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpfh_ctrl
// Sequencer: table clearing pass, fault evaluation, victim update, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpfh_ctrl import dpfh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  dpfh_status_t status_i,
  output dpfh_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EVAL   = 5'b00100,
    S_EVAL_V = 5'b01000,
    S_DONE   = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE) || cfg_we_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.need_victim ? S_EVAL_V : S_DONE;
      end
      S_EVAL_V: begin
        cmd_o.eval_v = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // a register write starts a clearing pass of the page table
    if (cfg_we_i) begin
      cmd_o           = '0;
      cmd_o.clr_start = 1'b1;
      state_d         = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> state_q == S_CLEAR)
    else $error("register write did not start a clearing pass");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("output register overwritten");

  a_eval_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && !cfg_we_i) |=> (state_q == S_EVAL_V || state_q == S_DONE))
    else $error("evaluation left to wrong state");
`endif

endmodule

// ===== hdl/demand_paging_fault_handler.sv =====
// ----------------------------------------------------------------------------
// demand_paging_fault_handler
// Serves page faults of one zone: upgrade, reprotect, error, zero fill, swap in or
// eviction of the page in frame 0, keeping the page table and the frame state.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid_i / in_stall_o      fault_page_i
//   out      output     out_valid_o / out_stall_i    action_o .. victim_writeback_o
//   cfg      input      cfg_we_i                     cfg_index_i, cfg_data_i
//
// Each item goes S_EVAL, S_EVAL_V (only when an eviction reads back the victim
// entry through the single page table port), S_DONE; then the next is taken.
// After reset and after every register write a clearing pass sweeps all
// MAX_PAGES entries of the page table; in_stall_o stays high meanwhile.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module demand_paging_fault_handler import dpfh_pkg::*; #(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PAGE_W-1:0]     fault_page_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ACT_W-1:0]      action_o,
  output logic [FIDX_W-1:0]     frame_index_o,
  output logic [PROT_W-1:0]     new_protection_o,
  output logic                  victim_valid_o,
  output logic [PAGE_W-1:0]     victim_page_o,
  output logic                  victim_writeback_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dpfh_cmd_t    cmd;
  dpfh_status_t status;

  dpfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpfh_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .fault_page_i       (fault_page_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .action_o           (action_o),
    .frame_index_o      (frame_index_o),
    .new_protection_o   (new_protection_o),
    .victim_valid_o     (victim_valid_o),
    .victim_page_o      (victim_page_o),
    .victim_writeback_o (victim_writeback_o)
  );

endmodule
